/* src/cadu_pkg.sv */
// Package with the shared types and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
package cadu_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam int WORD_W    = 32;
  localparam int MAG_W     = 64;
  localparam int SUM_W     = 65;
  localparam int QUOT_BITS = 32;

  typedef enum logic [2:0] {
    CLS_ADD,
    CLS_MUL,
    CLS_DIV,
    CLS_DIV_ZERO,
    CLS_NONE
  } op_cls_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    op_cls_t            cls;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } job_t;

endpackage

/* src/cadu_front.sv */
// Front end: accepts requests, classifies the operation and queues the jobs.
`timescale 1ns / 1ps
module cadu_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cadu_pkg::req_t  in_data,
  output logic            job_valid,
  input  logic            job_ready,
  output cadu_pkg::job_t  job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cadu_pkg::job_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  cadu_pkg::job_t       job_new;
  logic                 push;
  logic                 pop;

  always_comb begin
    job_new.a_real = in_data.a_real;
    job_new.a_imag = in_data.a_imag;
    job_new.b_real = in_data.b_real;
    job_new.b_imag = in_data.b_imag;
    case (in_data.req_type)
      cadu_pkg::OP_ADD: job_new.cls = cadu_pkg::CLS_ADD;
      cadu_pkg::OP_MUL: job_new.cls = cadu_pkg::CLS_MUL;
      cadu_pkg::OP_DIV: begin
        if (in_data.b_real == '0 && in_data.b_imag == '0) begin
          job_new.cls = cadu_pkg::CLS_DIV_ZERO;
        end else begin
          job_new.cls = cadu_pkg::CLS_DIV;
        end
      end
      default: job_new.cls = cadu_pkg::CLS_NONE;
    endcase
  end

  assign in_ready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign job_valid = (count_r != '0);
  assign job       = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_new;
    end
  end

endmodule

/* src/cadu_div_step.sv */
// One registered step of the restoring divider that forms one quotient bit.
`timescale 1ns / 1ps
module cadu_div_step (
  input  logic                                clk,
  input  logic                                en,
  input  logic [cadu_pkg::MAG_W-1:0]          d,
  input  logic [cadu_pkg::MAG_W-1:0]          rem_in,
  input  logic [cadu_pkg::QUOT_BITS-1:0]      nlow_in,
  input  logic [cadu_pkg::QUOT_BITS-1:0]      q_in,
  output logic [cadu_pkg::MAG_W-1:0]          rem_out,
  output logic [cadu_pkg::QUOT_BITS-1:0]      nlow_out,
  output logic [cadu_pkg::QUOT_BITS-1:0]      q_out
);

  localparam int MW = cadu_pkg::MAG_W;
  localparam int QW = cadu_pkg::QUOT_BITS;

  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic          fits;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] nlow_r, nlow_nxt;
  logic [QW-1:0] q_r, q_nxt;

  always_comb begin
    trial    = {rem_in, nlow_in[QW-1]};
    diff     = trial - {1'b0, d};
    fits     = (trial >= {1'b0, d});
    rem_nxt  = fits ? diff[MW-1:0] : trial[MW-1:0];
    q_nxt    = {q_in[QW-2:0], fits};
    nlow_nxt = {nlow_in[QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nlow_r <= nlow_nxt;
      q_r    <= q_nxt;
    end
  end

  assign rem_out  = rem_r;
  assign nlow_out = nlow_r;
  assign q_out    = q_r;

endmodule

/* src/cadu_back.sv */
// Back end: pipelined products, sums, divider and saturation of the result.
`timescale 1ns / 1ps
module cadu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  cadu_pkg::job_t  job,
  output logic            out_valid,
  input  logic            out_ready,
  output cadu_pkg::res_t  out_data
);

  localparam int MW    = cadu_pkg::MAG_W;
  localparam int SW    = cadu_pkg::SUM_W;
  localparam int WW    = cadu_pkg::WORD_W;
  localparam int QW    = cadu_pkg::QUOT_BITS;
  localparam int STEPS = cadu_pkg::QUOT_BITS;
  localparam int INT_SHIFT = WW - FRAC_BITS;

  typedef struct packed {
    cadu_pkg::op_cls_t cls;
    logic [1:0]        neg;
    logic [1:0]        big;
    logic [1:0][WW-1:0] low;
  } side_t;

  logic en;

  // Stage 1: products.
  logic                     v1_r;
  cadu_pkg::op_cls_t        cls1_r;
  logic signed [MW-1:0]     p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq_r_r, sq_i_r;
  logic signed [WW:0]       add_re_r, add_im_r;

  // Stage 2: sums.
  logic                     v2_r;
  cadu_pkg::op_cls_t        cls2_r;
  logic signed [SW-1:0]     s_r [2];
  logic signed [SW-1:0]     s_nxt [2];
  logic [MW-1:0]            d2_r;

  // Stage 3: sign and magnitude.
  logic                     v3_r;
  cadu_pkg::op_cls_t        cls3_r;
  logic [1:0]               neg3_r;
  logic [MW-1:0]            mag3_r [2];
  logic [MW-1:0]            d3_r;

  // Stage 4 and divider steps.
  logic                     vld_r [STEPS+1];
  side_t                    side_r [STEPS+1];
  side_t                    side_nxt;
  logic [MW-1:0]            dp_r [STEPS+1];
  logic [MW-1:0]            rem_w [2][STEPS+1];
  logic [QW-1:0]            nlow_w [2][STEPS+1];
  logic [QW-1:0]            q_w [2][STEPS+1];
  logic [MW-1:0]            rem0_r [2];
  logic [QW-1:0]            nlow0_r [2];
  logic [MW-1:0]            rem_nxt [2];
  logic [QW-1:0]            nlow_nxt [2];
  logic [MW-1:0]            shr_frac [2];
  logic [MW-1:0]            shr_int [2];

  // Output.
  logic                     out_valid_r;
  cadu_pkg::res_t           out_data_r, out_data_nxt;
  logic [WW-1:0]            fin_low [2];
  logic                     fin_big [2];
  logic                     fin_sat [2];
  logic [WW-1:0]            fin_val [2];

  assign en        = !out_valid_r || out_ready;
  assign job_ready = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r   <= job.cls;
      p_rr_r   <= job.a_real * job.b_real;
      p_ii_r   <= job.a_imag * job.b_imag;
      p_ri_r   <= job.a_real * job.b_imag;
      p_ir_r   <= job.a_imag * job.b_real;
      sq_r_r   <= job.b_real * job.b_real;
      sq_i_r   <= job.b_imag * job.b_imag;
      add_re_r <= job.a_real + job.b_real;
      add_im_r <= job.a_imag + job.b_imag;
    end
  end

  always_comb begin
    case (cls1_r)
      cadu_pkg::CLS_ADD: begin
        s_nxt[0] = SW'(add_re_r);
        s_nxt[1] = SW'(add_im_r);
      end
      cadu_pkg::CLS_MUL: begin
        s_nxt[0] = SW'(p_rr_r) - SW'(p_ii_r);
        s_nxt[1] = SW'(p_ri_r) + SW'(p_ir_r);
      end
      cadu_pkg::CLS_DIV: begin
        s_nxt[0] = SW'(p_rr_r) + SW'(p_ii_r);
        s_nxt[1] = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        s_nxt[0] = '0;
        s_nxt[1] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls2_r <= cls1_r;
      s_r[0] <= s_nxt[0];
      s_r[1] <= s_nxt[1];
      d2_r   <= $unsigned(sq_r_r) + $unsigned(sq_i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls3_r <= cls2_r;
      d3_r   <= d2_r;
      for (int l = 0; l < 2; l++) begin
        neg3_r[l] <= s_r[l][SW-1];
        mag3_r[l] <= s_r[l][SW-1] ? MW'(-s_r[l]) : s_r[l][MW-1:0];
      end
    end
  end

  always_comb begin
    side_nxt.cls = cls3_r;
    for (int l = 0; l < 2; l++) begin
      shr_frac[l]     = mag3_r[l] >> FRAC_BITS;
      shr_int[l]      = mag3_r[l] >> INT_SHIFT;
      side_nxt.neg[l] = neg3_r[l];
      rem_nxt[l]      = shr_int[l];
      nlow_nxt[l]     = mag3_r[l][QW-1:0] << FRAC_BITS;
      case (cls3_r)
        cadu_pkg::CLS_ADD: begin
          side_nxt.big[l] = |mag3_r[l][MW-1:WW];
          side_nxt.low[l] = mag3_r[l][WW-1:0];
        end
        cadu_pkg::CLS_MUL: begin
          side_nxt.big[l] = |shr_frac[l][MW-1:WW];
          side_nxt.low[l] = shr_frac[l][WW-1:0];
        end
        cadu_pkg::CLS_DIV: begin
          side_nxt.big[l] = (shr_int[l] >= d3_r);
          side_nxt.low[l] = '0;
        end
        default: begin
          side_nxt.big[l] = 1'b0;
          side_nxt.low[l] = '0;
          side_nxt.neg[l] = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      dp_r[0]   <= d3_r;
      for (int l = 0; l < 2; l++) begin
        rem0_r[l]  <= rem_nxt[l];
        nlow0_r[l] <= nlow_nxt[l];
      end
      for (int k = 0; k < STEPS; k++) begin
        side_r[k+1] <= side_r[k];
        dp_r[k+1]   <= dp_r[k];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rem_w[l][0]  = rem0_r[l];
    assign nlow_w[l][0] = nlow0_r[l];
    assign q_w[l][0]    = '0;
    for (genvar k = 0; k < STEPS; k++) begin : g_step
      cadu_div_step u_step (
        .clk      (clk),
        .en       (en),
        .d        (dp_r[k]),
        .rem_in   (rem_w[l][k]),
        .nlow_in  (nlow_w[l][k]),
        .q_in     (q_w[l][k]),
        .rem_out  (rem_w[l][k+1]),
        .nlow_out (nlow_w[l][k+1]),
        .q_out    (q_w[l][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r     <= job_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      vld_r[0] <= v3_r;
      for (int k = 0; k < STEPS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_big[l] = side_r[STEPS].big[l];
      fin_low[l] = (side_r[STEPS].cls == cadu_pkg::CLS_DIV) ?
                   q_w[l][STEPS] : side_r[STEPS].low[l];
      if (side_r[STEPS].neg[l]) begin
        fin_sat[l] = fin_big[l] || (fin_low[l] > 32'h8000_0000);
        fin_val[l] = fin_sat[l] ? 32'h8000_0000 : (32'd0 - fin_low[l]);
      end else begin
        fin_sat[l] = fin_big[l] || fin_low[l][WW-1];
        fin_val[l] = fin_sat[l] ? 32'h7FFF_FFFF : fin_low[l];
      end
    end
    out_data_nxt.res_real = fin_val[0];
    out_data_nxt.res_imag = fin_val[1];
    if (side_r[STEPS].cls == cadu_pkg::CLS_DIV_ZERO) begin
      out_data_nxt.status = cadu_pkg::ST_DIV_ZERO;
    end else if (fin_sat[0] || fin_sat[1]) begin
      out_data_nxt.status = cadu_pkg::ST_SAT;
    end else begin
      out_data_nxt.status = cadu_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* src/complex_add_mul_div_unit.sv */
// Top level of the complex arithmetic unit for add, multiply and divide.
// The unit takes one request transfer per clock unless out_ready holds the pipeline, and
// returns one result transfer per request, in order. A request passes a small queue and
// then a fixed pipeline of 37 stages, in which the 32 stages of the restoring divider,
// one quotient bit each, make up most of the depth; all operations travel the same path.
// Results saturate to Q16.16, and a divisor of zero gives a zero result with a
// divide-by-zero status.
`timescale 1ns / 1ps
module complex_add_mul_div_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cadu_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cadu_pkg::res_t  out_data
);

  logic           job_valid;
  logic           job_ready;
  cadu_pkg::job_t job;

  cadu_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  cadu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
